/* rtl/core/rgbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rgbm_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int WINDOW_DEF    = 7;
	localparam int MAX_HEIGHT    = 4096;
	localparam int ROW_W         = 13;
	localparam int PIX_W         = 24;
	localparam int CFG_W         = 32;
	localparam int PADDR_W       = 3;

	localparam int IMG_WIDTH_W   = 11;
	localparam int IMG_HEIGHT_W  = 13;
	localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 11'd640;
	localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 13'd480;

	// register index, taken from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_GATHER,
		ST_RANK,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic accept;
		logic start_gather;
		logic run_gather;
		logic start_rank;
		logic run_rank;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic give;
		logic gather_done;
		logic rank_done;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/rgbm_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rgbm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/rgbm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rgbm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

/* rtl/core/rgbm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rgbm_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire rgbm_pkg::dp_status_t   st,
	output rgbm_pkg::ctrl_cmd_t         cmd
);
	rgbm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rgbm_pkg::ST_IDLE: begin
				if (in_valid && st.give) state_d = rgbm_pkg::ST_SETUP;
			end
			rgbm_pkg::ST_SETUP:  state_d = rgbm_pkg::ST_GATHER;
			rgbm_pkg::ST_GATHER: begin
				if (st.gather_done) state_d = rgbm_pkg::ST_RANK;
			end
			rgbm_pkg::ST_RANK: begin
				if (st.rank_done) state_d = rgbm_pkg::ST_HOLD;
			end
			rgbm_pkg::ST_HOLD: begin
				if (!st.out_busy) state_d = rgbm_pkg::ST_IDLE;
			end
			default: state_d = rgbm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rgbm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			rgbm_pkg::ST_SETUP: cmd.start_gather = 1'b1;
			rgbm_pkg::ST_GATHER: begin
				cmd.run_gather = !st.gather_done;
				cmd.start_rank = st.gather_done;
			end
			rgbm_pkg::ST_RANK: cmd.run_rank = !st.rank_done;
			rgbm_pkg::ST_HOLD: cmd.load_out = !st.out_busy;
			default: ;
		endcase
	end
endmodule

`default_nettype wire

/* rtl/core/rgbm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module rgbm_datapath #(
	parameter int MAX_WIDTH = rgbm_pkg::MAX_WIDTH_DEF,
	parameter int WINDOW    = rgbm_pkg::WINDOW_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [$clog2(MAX_WIDTH):0]          w_eff,
	input  wire logic [rgbm_pkg::ROW_W-1:0]          h_eff,
	input  wire logic                                cfg_clear,
	input  wire rgbm_pkg::ctrl_cmd_t                 cmd,
	output rgbm_pkg::dp_status_t                     st,
	input  wire rgbm_pkg::in_item_t                  in_item,
	output rgbm_pkg::out_item_t                      out_item,
	output logic                                     out_valid,
	input  wire logic                                out_ready
);
	localparam int HALF  = WINDOW / 2;
	localparam int SPAN  = 2 * HALF + 1;
	localparam int N     = SPAN * SPAN;
	localparam int RING  = 2 * HALF + 2;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RB    = $clog2(RING);
	localparam int RW    = rgbm_pkg::ROW_W;
	localparam int SB    = $clog2(SPAN);
	localparam int NB    = $clog2(N + 1);
	localparam int PB    = $clog2(SPAN + 2);
	localparam int AW    = RB + CW;
	localparam int DEPTH = RING * (2 ** CW);
	localparam int PW    = rgbm_pkg::PIX_W;

	function automatic logic [RB-1:0] ring_next(input logic [RB-1:0] r);
		ring_next = (r == RB'(RING - 1)) ? '0 : r + RB'(1);
	endfunction

	// raster counters
	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RB-1:0] in_ring_q, out_ring_q;

	// accept-time decision
	logic          clr;
	logic [RW-1:0] pr, por;
	logic [CW-1:0] pc, poc;
	logic [RB-1:0] pring;
	logic [CW:0]   nc1, ncol;
	logic [RW:0]   nrow, srow, nr;
	logic [RB-1:0] nring;
	logic [CW+1:0] scol, ncl;
	logic          give_pix;

	always_comb begin
		clr   = in_row_q >= h_eff;
		pr    = clr ? '0 : in_row_q;
		pc    = clr ? '0 : in_col_q;
		pring = clr ? '0 : in_ring_q;
		por   = clr ? '0 : out_row_q;
		poc   = clr ? '0 : out_col_q;
		nc1   = {1'b0, pc} + (CW+1)'(1);
		if (nc1 == w_eff) begin
			ncol  = '0;
			nrow  = {1'b0, pr} + (RW+1)'(1);
			nring = ring_next(pring);
		end else begin
			ncol  = nc1;
			nrow  = {1'b0, pr};
			nring = pring;
		end
		srow = {1'b0, por} + (RW+1)'(HALF);
		nr   = (srow < {1'b0, h_eff}) ? srow : {1'b0, h_eff} - (RW+1)'(1);
		scol = {2'b0, poc} + (CW+2)'(HALF);
		ncl  = (scol < {1'b0, w_eff}) ? scol : {1'b0, w_eff} - (CW+2)'(1);
		give_pix = (nrow > nr) || ((nrow == nr) && ({1'b0, ncol} > ncl));
	end

	logic out_last;
	assign out_last = ({1'b0, out_col_q} == w_eff - (CW+1)'(1)) &&
		(out_row_q == h_eff - RW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_ring_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_ring_q <= '0;
		end else if (cfg_clear) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_ring_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_ring_q <= '0;
		end else if (cmd.accept && in_item.kind == rgbm_pkg::KIND_PIXEL) begin
			in_row_q  <= nrow[RW-1:0];
			in_col_q  <= ncol[CW-1:0];
			in_ring_q <= nring;
			if (clr) begin
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_ring_q <= '0;
			end
		end else if (cmd.load_out) begin
			if (out_last) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_ring_q  <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_ring_q <= '0;
			end else if ({1'b0, out_col_q} + (CW+1)'(1) == w_eff) begin
				out_col_q  <= '0;
				out_row_q  <= out_row_q + RW'(1);
				out_ring_q <= ring_next(out_ring_q);
			end else begin
				out_col_q <= out_col_q + CW'(1);
			end
		end
	end

	// line store
	logic [AW-1:0] raddr;
	logic [PW-1:0] rd_data;

	rgbm_ram #(
		.WIDTH (PW),
		.DEPTH (DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (cmd.accept && in_item.kind == rgbm_pkg::KIND_PIXEL),
		.waddr ({pring, pc}),
		.wdata ({in_item.red_in, in_item.green_in, in_item.blue_in}),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// window gather: one read per cycle, row by row
	logic [SB-1:0]        gr_q, gc_q;
	logic                 gdone_q;
	logic signed [RW:0]   grow_q;
	logic signed [CW+1:0] gcol_q;
	logic [RB-1:0]        gring_q;
	logic                 iss_s1, inb_s1;
	logic [NB-1:0]        n_q;
	logic                 inb;
	logic signed [CW+1:0] gcol0;

	assign gcol0 = $signed({2'b0, out_col_q}) - $signed((CW+2)'(HALF));
	assign inb = (grow_q >= 0) && (grow_q < $signed({1'b0, h_eff})) &&
		(gcol_q >= 0) && (gcol_q < $signed({1'b0, w_eff}));
	assign raddr = {gring_q, gcol_q[CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gr_q    <= '0;
			gc_q    <= '0;
			gdone_q <= 1'b1;
			iss_s1  <= 1'b0;
			inb_s1  <= 1'b0;
			n_q     <= '0;
			grow_q  <= '0;
			gcol_q  <= '0;
			gring_q <= '0;
		end else begin
			iss_s1 <= cmd.run_gather && !gdone_q;
			inb_s1 <= inb;
			if (iss_s1 && inb_s1) n_q <= n_q + NB'(1);
			if (cmd.start_gather) begin
				gr_q    <= '0;
				gc_q    <= '0;
				gdone_q <= 1'b0;
				n_q     <= '0;
				grow_q  <= $signed({1'b0, out_row_q}) - $signed((RW+1)'(HALF));
				gcol_q  <= gcol0;
				gring_q <= (out_ring_q >= RB'(HALF)) ? out_ring_q - RB'(HALF)
					: out_ring_q + RB'(RING - HALF);
			end else if (cmd.run_gather && !gdone_q) begin
				if (gc_q == SB'(SPAN - 1)) begin
					gc_q    <= '0;
					gcol_q  <= gcol0;
					gr_q    <= gr_q + SB'(1);
					grow_q  <= grow_q + (RW+1)'(1);
					gring_q <= ring_next(gring_q);
					if (gr_q == SB'(SPAN - 1)) gdone_q <= 1'b1;
				end else begin
					gc_q   <= gc_q + SB'(1);
					gcol_q <= gcol_q + (CW+2)'(1);
				end
			end
		end
	end

	// rank search: one window row of comparisons per cycle
	logic [PW-1:0] win_q [N];
	logic [N-1:0]  wv_q;
	logic [PB-1:0] ph_q;
	logic [NB-1:0] ci_q;
	logic          found_q;
	logic [PW-1:0] cand_q, res_q;
	logic          candv_q;
	logic [NB-1:0] lt_q, le_q, lt_sum, le_sum, kpick;
	logic          ph_cmp, ph_chk;

	assign ph_cmp = cmd.run_rank && (ph_q != '0) && (ph_q <= PB'(SPAN));
	assign ph_chk = cmd.run_rank && (ph_q == PB'(SPAN + 1));
	assign kpick  = n_q >> 1;

	always_comb begin
		lt_sum = '0;
		le_sum = '0;
		for (int t = 0; t < SPAN; t++) begin
			if (wv_q[t] && win_q[t] < cand_q) lt_sum = lt_sum + NB'(1);
			if (wv_q[t] && win_q[t] <= cand_q) le_sum = le_sum + NB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (iss_s1) begin
			win_q[0] <= rd_data;
			wv_q[0]  <= inb_s1;
			for (int k = 1; k < N; k++) begin
				win_q[k] <= win_q[k-1];
				wv_q[k]  <= wv_q[k-1];
			end
		end else if (ph_cmp) begin
			for (int k = 0; k < N; k++) begin
				win_q[k] <= win_q[(k + SPAN >= N) ? k + SPAN - N : k + SPAN];
				wv_q[k]  <= wv_q[(k + SPAN >= N) ? k + SPAN - N : k + SPAN];
			end
		end else if (ph_chk) begin
			for (int k = 0; k < N; k++) begin
				win_q[k] <= win_q[(k + 1 >= N) ? k + 1 - N : k + 1];
				wv_q[k]  <= wv_q[(k + 1 >= N) ? k + 1 - N : k + 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_rank) begin
			res_q <= '0;
		end else if (cmd.run_rank) begin
			if (ph_q == '0) begin
				cand_q  <= win_q[0];
				candv_q <= wv_q[0];
				lt_q    <= '0;
				le_q    <= '0;
			end else if (ph_cmp) begin
				lt_q <= lt_q + lt_sum;
				le_q <= le_q + le_sum;
			end else if (ph_chk && candv_q && lt_q <= kpick && kpick < le_q) begin
				res_q <= cand_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= '0;
			ci_q    <= '0;
			found_q <= 1'b0;
		end else if (cmd.start_rank) begin
			ph_q    <= '0;
			ci_q    <= '0;
			found_q <= 1'b0;
		end else if (cmd.run_rank) begin
			if (ph_chk) begin
				ph_q <= '0;
				ci_q <= ci_q + NB'(1);
				if (candv_q && lt_q <= kpick && kpick < le_q) found_q <= 1'b1;
			end else begin
				ph_q <= ph_q + PB'(1);
			end
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_item.red_out   <= res_q[23:16];
			out_item.green_out <= res_q[15:8];
			out_item.blue_out  <= res_q[7:0];
			out_item.frame_end <= out_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign st.give        = (in_item.kind == rgbm_pkg::KIND_FLUSH) ? clr : give_pix;
	assign st.gather_done = gdone_q && !iss_s1;
	assign st.rank_done   = found_q || (ci_q == NB'(N));
	assign st.out_busy    = out_valid_q && !out_ready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still owed");

	a_median_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> found_q)
		else $error("rank search ended without a median");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_rank |-> (n_q != '0) && (n_q <= NB'(N)))
		else $error("window count out of range after gather");

	a_gather_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_rank |=> !iss_s1)
		else $error("line store read still in flight during rank search");
endmodule

`default_nettype wire

/* rtl/core/rgb_median_filter_7x7_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// RGB median filter over a clipped SPAN x SPAN neighbourhood, raster order.
// pix_in carries requests: kind 0 stores a pixel, kind 1 is a flush tick that
// drains one owed output once the whole frame has arrived. pix_out gives the
// median colour (ordered by red, then green, then blue) and frame_end on the
// last pixel of the frame. image_width (0x0) and image_height (0x4) sit on the
// APB port; a write restarts the frame; the user makes it only while the block
// idles, as the block does not enforce this. A request owing no output only
// moves the counters on. One giving an output runs setup, a gather of one line
// store read per window entry (N = SPAN * SPAN, SPAN = 2 * (WINDOW / 2) + 1),
// then a search comparing one window row against each candidate per cycle,
// ending early once the median is found, then a load of the output register.
// The next request is taken while a finished result waits in the output
// register; if the receiver stalls, the next output waits until that register
// is free. Reset clears all counters; the line store holds no reset value and
// is read only where it has been written in the current frame.
module rgb_median_filter_7x7_unit #(
	parameter int MAX_WIDTH = rgbm_pkg::MAX_WIDTH_DEF,
	parameter int WINDOW    = rgbm_pkg::WINDOW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rgbm_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rgbm_pkg::CFG_W-1:0]   pwdata,
	output logic      [rgbm_pkg::CFG_W-1:0]   prdata,
	output logic                              pready,
	rgbm_stream_if.sink                       pix_in,
	rgbm_stream_if.source                     pix_out
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = rgbm_pkg::ROW_W;

	logic [rgbm_pkg::IMG_WIDTH_W-1:0]  width_q;
	logic [rgbm_pkg::IMG_HEIGHT_W-1:0] height_q;
	logic                              cfg_wr;
	logic [CW:0]                       w_eff;
	logic [RW-1:0]                     h_eff;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgbm_pkg::IMG_WIDTH_RST;
			height_q <= rgbm_pkg::IMG_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				rgbm_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[rgbm_pkg::IMG_WIDTH_W-1:0];
				rgbm_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[rgbm_pkg::IMG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rgbm_pkg::REG_IMAGE_WIDTH:  prdata = rgbm_pkg::CFG_W'(width_q);
			rgbm_pkg::REG_IMAGE_HEIGHT: prdata = rgbm_pkg::CFG_W'(height_q);
			default:                    prdata = '0;
		endcase
	end

	// clamp to the supported frame size
	always_comb begin
		if (width_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(width_q);
		end
		if (height_q == '0) begin
			h_eff = RW'(1);
		end else if (32'(height_q) > rgbm_pkg::MAX_HEIGHT) begin
			h_eff = RW'(rgbm_pkg::MAX_HEIGHT);
		end else begin
			h_eff = RW'(height_q);
		end
	end

	rgbm_pkg::ctrl_cmd_t  cmd;
	rgbm_pkg::dp_status_t st;

	rgbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.st       (st),
		.cmd      (cmd)
	);

	rgbm_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.WINDOW    (WINDOW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.cfg_clear (cfg_wr),
		.cmd       (cmd),
		.st        (st),
		.in_item   (pix_in.data),
		.out_item  (pix_out.data),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready)
	);
endmodule

`default_nettype wire

/* tb/tb_rgb_median_filter_7x7_unit.sv */
`timescale 1ns / 1ps

module tb_rgb_median_filter_7x7_unit;

	localparam int RING_ROWS  = 8;
	localparam int HALF       = rgbm_pkg::WINDOW_DEF / 2;
	localparam int WIN_N      = (2 * HALF + 1) * (2 * HALF + 1);
	localparam int MW         = rgbm_pkg::MAX_WIDTH_DEF;
	localparam int SETTLE     = 700;
	localparam int LIMIT      = 4000000;
	localparam int ITEM_GOAL  = 1700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [rgbm_pkg::PADDR_W-1:0] paddr = '0;
	logic [rgbm_pkg::CFG_W-1:0] pwdata = '0;
	logic [rgbm_pkg::CFG_W-1:0] prdata;
	logic pready;

	rgbm_stream_if #(.payload_t(rgbm_pkg::in_item_t))  pix_in();
	rgbm_stream_if #(.payload_t(rgbm_pkg::out_item_t)) pix_out();

	rgb_median_filter_7x7_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix_in(pix_in.sink), .pix_out(pix_out.source)
	);

	always #1 clk = ~clk;

	// filter state as the block should hold it
	logic [23:0] line_ring [0:RING_ROWS*MW-1];
	int unsigned next_col, next_row, out_pos;
	int unsigned width_reg, height_reg;
	rgbm_pkg::out_item_t median_q[$];

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int frames_run = 0;
	int hold_cycles = 0;
	int burst_left = 0;
	bit drv_on = 1'b0;

	initial begin
		pix_in.valid = 1'b0;
		pix_in.data = '0;
		pix_out.ready = 1'b0;
		for (int i = 0; i < RING_ROWS*MW; i++) line_ring[i] = '0;
		next_col = 0; next_row = 0; out_pos = 0;
		width_reg = 640; height_reg = 480;
	end

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
	endtask

	function automatic int unsigned eff_w();
		return (width_reg < 1) ? 1 : (width_reg > MW) ? MW : width_reg;
	endfunction

	function automatic int unsigned eff_h();
		return (height_reg < 1) ? 1 :
			(height_reg > rgbm_pkg::MAX_HEIGHT) ? rgbm_pkg::MAX_HEIGHT : height_reg;
	endfunction

	function automatic void restart_frame();
		next_col = 0; next_row = 0; out_pos = 0;
	endfunction

	function automatic void push_median(int unsigned w, int unsigned h);
		logic [23:0] win [WIN_N];
		logic [23:0] pick;
		logic [23:0] v;
		int orow, ocol, r, c, n, i, j;
		rgbm_pkg::out_item_t o;
		orow = out_pos / w;
		ocol = out_pos % w;
		n = 0;
		for (r = orow - HALF; r <= orow + HALF; r++) begin
			if (r < 0 || r >= int'(h)) continue;
			for (c = ocol - HALF; c <= ocol + HALF; c++) begin
				if (c < 0 || c >= int'(w)) continue;
				win[n] = line_ring[(r % RING_ROWS)*MW + c];
				n++;
			end
		end
		for (i = 1; i < n; i++) begin
			v = win[i];
			j = i;
			while (j > 0 && win[j-1] > v) begin
				win[j] = win[j-1];
				j--;
			end
			win[j] = v;
		end
		pick = win[n/2];
		o.red_out = pick[23:16];
		o.green_out = pick[15:8];
		o.blue_out = pick[7:0];
		o.frame_end = (out_pos + 1 >= w*h);
		median_q.insert(median_q.size(), o);
		out_pos++;
		if (out_pos >= w*h) restart_frame();
	endfunction

	function automatic void predict_median(rgbm_pkg::in_item_t it);
		int unsigned w, h, total, orow, ocol, nr, nc;
		w = eff_w();
		h = eff_h();
		total = w*h;
		if (it.kind == rgbm_pkg::KIND_PIXEL) begin
			if (next_row >= h) restart_frame();
			line_ring[(next_row % RING_ROWS)*MW + (next_col % MW)] =
				{it.red_in, it.green_in, it.blue_in};
			next_col++;
			if (next_col >= w) begin
				next_col = 0;
				next_row++;
			end
			if (out_pos >= total) return;
			orow = out_pos / w;
			ocol = out_pos % w;
			nr = (orow + HALF < h) ? orow + HALF : h - 1;
			nc = (ocol + HALF < w) ? ocol + HALF : w - 1;
			if (next_row > nr || (next_row == nr && next_col > nc)) push_median(w, h);
		end else if (next_row >= h && out_pos < total) begin
			push_median(w, h);
		end
	endfunction

	// called just after a rising edge; returns just after the accepting edge, or after a random idle gap that follows it
	task automatic send_item(input logic kind, input logic [23:0] rgb);
		rgbm_pkg::in_item_t it;
		int gap;
		it.kind = kind;
		{it.red_in, it.green_in, it.blue_in} = rgb;
		pix_in.valid <= 1'b1;
		pix_in.data <= it;
		drv_on = 1'b1;
		do @(posedge clk); while (!pix_in.ready);
		predict_median(it);
		items_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 9);
			if (gap > 0) begin
				pix_in.valid <= 1'b0;
				drv_on = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic [23:0] rand_colour();
		// a narrow palette half of the time gives ties between window entries
		if ($urandom_range(0, 1))
			return {8'($urandom_range(0, 2) * 8'h7f), 8'($urandom_range(0, 1) * 8'hff),
				8'($urandom_range(0, 2) * 8'h80)};
		return 24'($urandom);
	endfunction

	// drop valid, wait out every owed result and any request still at work
	task automatic settle();
		if (drv_on) begin
			pix_in.valid <= 1'b0;
			drv_on = 1'b0;
		end
		while (median_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx,
		input logic [rgbm_pkg::CFG_W-1:0] val);
		logic [rgbm_pkg::CFG_W-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (wr) begin
			if (idx == rgbm_pkg::REG_IMAGE_WIDTH) width_reg = val & 32'h7ff;
			else height_reg = val & 32'h1fff;
			restart_frame();
		end else begin
			want = (idx == rgbm_pkg::REG_IMAGE_WIDTH) ? width_reg : height_reg;
			if (prdata !== want) report("prdata", prdata, want);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [rgbm_pkg::CFG_W-1:0] w,
		input logic [rgbm_pkg::CFG_W-1:0] h);
		settle();
		apb_access(1'b1, rgbm_pkg::REG_IMAGE_WIDTH, w);
		apb_access(1'b1, rgbm_pkg::REG_IMAGE_HEIGHT, h);
		apb_access(1'b0, rgbm_pkg::REG_IMAGE_WIDTH, '0);
		apb_access(1'b0, rgbm_pkg::REG_IMAGE_HEIGHT, '0);
		frames_run++;
	endtask

	task automatic flush_owed(input int extra);
		int owed;
		owed = (next_row >= eff_h()) ? eff_w()*eff_h() - out_pos : 0;
		repeat (owed + extra) send_item(rgbm_pkg::KIND_FLUSH, 24'($urandom));
	endtask

	task automatic test_small_frame();
		set_frame(3, 3);
		send_item(rgbm_pkg::KIND_FLUSH, 24'h000000);	// nothing owed yet: ignored
		send_item(rgbm_pkg::KIND_PIXEL, 24'h000000);
		send_item(rgbm_pkg::KIND_PIXEL, 24'hffffff);
		send_item(rgbm_pkg::KIND_PIXEL, 24'hff0000);
		send_item(rgbm_pkg::KIND_PIXEL, 24'h00ff00);
		send_item(rgbm_pkg::KIND_FLUSH, 24'hffffff);	// frame incomplete: ignored
		send_item(rgbm_pkg::KIND_PIXEL, 24'h0000ff);
		send_item(rgbm_pkg::KIND_PIXEL, 24'hff00ff);
		send_item(rgbm_pkg::KIND_PIXEL, 24'h00ffff);
		send_item(rgbm_pkg::KIND_PIXEL, 24'hffff00);
		send_item(rgbm_pkg::KIND_PIXEL, 24'h808080);
		flush_owed(2);
		// complete frame, drain partly, then a pixel drops the rest
		repeat (9) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
		send_item(rgbm_pkg::KIND_FLUSH, 24'h0);
		repeat (9) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
		flush_owed(1);
	endtask

	task automatic test_clamped_sizes();
		set_frame(32'hffff_f800, 32'hffff_e000);	// both fields zero: clamp to one pixel
		repeat (3) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
		set_frame(2047, 8191);	// clamp to the largest frame; fed only in part
		repeat (12) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
		set_frame(1, 4096);
		repeat (30) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
		set_frame(1024, 1);
		repeat (1024) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
		flush_owed(1);
	endtask

	task automatic test_backpressure();
		set_frame(8, 6);
		hold_cycles = 3000;
		repeat (48) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
		flush_owed(0);
	endtask

	task automatic test_random_frames();
		int w, h, n, mode;
		while (items_sent < ITEM_GOAL) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
			h = $urandom_range(1, 9);
			mode = $urandom_range(0, 9);
			set_frame(w, h);
			n = (mode == 7) ? $urandom_range(1, w*h) : w*h;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_item(rgbm_pkg::KIND_FLUSH, 24'($urandom));
				send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
			end
			if (mode == 8) begin
				repeat ($urandom_range(0, 3)) send_item(rgbm_pkg::KIND_FLUSH, 24'($urandom));
				repeat (w*h) send_item(rgbm_pkg::KIND_PIXEL, rand_colour());
			end
			flush_owed($urandom_range(0, 2));
		end
	endtask

	// receiver: long hold-off when asked, else a stall pattern of its own
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pix_out.ready <= 1'b0;
		end else begin
			case ((cycles / 256) % 4)
				0: pix_out.ready <= 1'b1;
				1: pix_out.ready <= ($urandom_range(0, 3) != 0);
				2: pix_out.ready <= ($urandom_range(0, 1) != 0);
				default: pix_out.ready <= ((cycles % 5) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		rgbm_pkg::out_item_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			results_seen++;
			if (median_q.size() == 0) begin
				report("unexpected result", pix_out.data, 0);
			end else begin
				want = median_q.pop_front();
				if (pix_out.data.red_out !== want.red_out)
					report("red_out", pix_out.data.red_out, want.red_out);
				if (pix_out.data.green_out !== want.green_out)
					report("green_out", pix_out.data.green_out, want.green_out);
				if (pix_out.data.blue_out !== want.blue_out)
					report("blue_out", pix_out.data.blue_out, want.blue_out);
				if (pix_out.data.frame_end !== want.frame_end)
					report("frame_end", pix_out.data.frame_end, want.frame_end);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_frame();
		test_clamped_sizes();
		test_backpressure();
		test_random_frames();
		settle();
		$display("%0d requests over %0d frame settings, %0d medians checked,",
			items_sent, frames_run, results_seen);
		$display("with clamped sizes, dropped frames, stray flushes and a long output stall");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
